// ===== rtl/pwsf_pkg.sv =====
// Shared widths, codes and sideband types of the pairwise spring force pipeline.
package pwsf_pkg;

    localparam int FRAC_BITS = 16;

    localparam int COORD_W    = 32;
    localparam int CFG_W      = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int ENERGY_W   = 48;

    localparam int S_TDATA_W = 200;
    localparam int M_TDATA_W = 248;

    localparam int AD_W      = COORD_W + 1;
    localparam int SUM_W     = 2 * AD_W;
    localparam int DIST_W    = AD_W;
    localparam int STRETCH_W = DIST_W + 1;
    localparam int AS_W      = DIST_W;
    localparam int P_W       = CFG_W + AS_W;
    localparam int MM_W      = P_W + 1 - FRAC_BITS;
    localparam int MM_LO_W   = (MM_W + 1) / 2;
    localparam int MM_HI_W   = MM_W - MM_LO_W;
    localparam int INNER_W   = P_W + 1;
    localparam int INNER_LO_W = (INNER_W + 1) / 2;
    localparam int INNER_HI_W = INNER_W - INNER_LO_W;
    localparam int E_W       = AS_W + INNER_W;
    localparam int N_W       = AD_W + MM_W;
    localparam int Q_BITS    = COORD_W + 1;
    localparam int QC_W      = Q_BITS + 1;
    localparam int R_W       = DIST_W + Q_BITS;

    localparam int SQRT_LAT = DIST_W;
    localparam int DIV_LAT  = Q_BITS + 1;
    localparam int PIPE_LAT = 3 + SQRT_LAT + 5 + DIV_LAT + 1;

    localparam logic [CFG_W-1:0] K_RESET  = CFG_W'(1) << FRAC_BITS;
    localparam logic [CFG_W-1:0] EQ_RESET = CFG_W'(2) << FRAC_BITS;
    localparam logic [CFG_W-1:0] RF_RESET = '0;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SPRING_K  = 2'd0,
        CFG_EQ_DIST   = 2'd1,
        CFG_REPULSION = 2'd2
    } cfg_addr_t;

    typedef struct packed {
        logic [2:0][AD_W-1:0] ad;
        logic [2:0]           neg;
        logic                 repel;
        logic                 sf;
        logic                 df;
    } sq_side_t;

endpackage

// ===== rtl/pairwise_spring_force.sv =====
// Pairwise spring force: distance, stretch, force vector and energy in one pipeline.
// One request enters per cycle while no held result stalls the pipeline.
// The depth is set by the bit-per-stage square root (33) and divider (34) pipelines.
// A held result stalls the whole pipeline until it is taken.
// Reset clears all valid bits and loads k = 1.0, rest distance = 2.0, repulsion = 0.
module pairwise_spring_force (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // src_x, src_y, src_z, dst_x, dst_y, dst_z, src_fixed, dst_fixed, zero pad
    input  logic [pwsf_pkg::S_TDATA_W-1:0]     s_tdata,
    // req_type
    input  logic [0:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // src_acc_x, src_acc_y, src_acc_z, dst_acc_x, dst_acc_y, dst_acc_z,
    // spring_energy, spring_active, zero pad
    output logic [pwsf_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pwsf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [pwsf_pkg::CFG_W-1:0]         cfg_data
);

    localparam int CW  = pwsf_pkg::COORD_W;
    localparam int AW  = pwsf_pkg::AD_W;
    localparam int DW  = pwsf_pkg::DIST_W;
    localparam int SW  = pwsf_pkg::STRETCH_W;
    localparam int ASW = pwsf_pkg::AS_W;
    localparam int MW  = pwsf_pkg::MM_W;
    localparam int MLW = pwsf_pkg::MM_LO_W;
    localparam int MHW = pwsf_pkg::MM_HI_W;
    localparam int IW  = pwsf_pkg::INNER_W;
    localparam int ILW = pwsf_pkg::INNER_LO_W;
    localparam int IHW = pwsf_pkg::INNER_HI_W;
    localparam int EW  = pwsf_pkg::E_W;
    localparam int NW  = pwsf_pkg::N_W;
    localparam int QW  = pwsf_pkg::QC_W;
    localparam int GW  = pwsf_pkg::ENERGY_W;
    localparam int FB  = pwsf_pkg::FRAC_BITS;
    localparam int EH  = 2 * FB + GW;
    localparam int PL  = pwsf_pkg::PIPE_LAT;
    localparam int DL  = pwsf_pkg::DIV_LAT;
    localparam int PAD = pwsf_pkg::M_TDATA_W - 6 * CW - GW - 1;

    typedef struct packed {
        logic [2:0][AW-1:0] ad;
        logic [DW-1:0]      sep;
        logic [2:0]         pos;
        logic               act;
        logic               repel;
        logic               sf;
        logic               df;
    } mid_t;

    typedef struct packed {
        logic [GW-1:0] energy;
        logic [2:0]    pos;
        logic          act;
        logic          sf;
        logic          df;
    } out_side_t;

    logic [pwsf_pkg::CFG_W-1:0] k_reg;
    logic [pwsf_pkg::CFG_W-1:0] eq_reg;
    logic [pwsf_pkg::CFG_W-1:0] rf_reg;

    logic [PL-1:0] vld_reg;
    logic          en;

    pwsf_pkg::sq_side_t   side0_reg;
    pwsf_pkg::sq_side_t   side1_reg;
    pwsf_pkg::sq_side_t   side2_reg;
    logic [2:0][2*AW-1:0] sq1_reg;
    logic [pwsf_pkg::SUM_W-1:0] sum2_reg;

    logic [DW-1:0]        sep;
    pwsf_pkg::sq_side_t   sq_side;

    mid_t                 mid_reg [5];
    logic [ASW-1:0]       as_reg  [3];
    logic [pwsf_pkg::P_W-1:0] p4_reg;
    logic [MW-1:0]        mm5_reg;
    logic [IW-1:0]        inner5_reg;
    logic [2:0][AW+MLW-1:0] fplo6_reg;
    logic [2:0][AW+MHW-1:0] fphi6_reg;
    logic [ASW+ILW-1:0]   eplo6_reg;
    logic [ASW+IHW-1:0]   ephi6_reg;
    logic [2:0][NW-1:0]   num7_reg;
    logic [EW-1:0]        e7_reg;

    logic [2:0][QW-1:0]   quo;
    out_side_t            dside_reg [DL];
    logic [pwsf_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [SW-1:0]        stretch_next;
    logic                 cond_next;
    mid_t                 mid_next;
    logic [ASW-1:0]       as_next;
    out_side_t            oside_next;
    logic [2:0][CW-1:0]   src_acc_next;
    logic [2:0][CW-1:0]   dst_acc_next;
    logic [GW-1:0]        energy_next;

    function automatic logic [CW-1:0] sat_acc(input logic [QW-1:0] mag, input logic neg);
        logic [QW-1:0] lim;
        logic [QW-1:0] m;
        lim = neg ? (QW'(1) << (CW - 1)) : ((QW'(1) << (CW - 1)) - QW'(1));
        m   = (mag > lim) ? lim : mag;
        return neg ? CW'(QW'(0) - m) : CW'(m);
    endfunction

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg  <= pwsf_pkg::K_RESET;
            eq_reg <= pwsf_pkg::EQ_RESET;
            rf_reg <= pwsf_pkg::RF_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_addr)
                pwsf_pkg::CFG_SPRING_K:  k_reg  <= cfg_data;
                pwsf_pkg::CFG_EQ_DIST:   eq_reg <= cfg_data;
                pwsf_pkg::CFG_REPULSION: rf_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits advance together; a held result freezes every stage.
    assign en       = !vld_reg[PL-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[PL-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PL-2:0], s_tvalid};
        end
    end

    // Deltas, squares and their sum.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic signed [AW-1:0] d;
                d = AW'($signed(s_tdata[3*CW+CW*i +: CW])) - AW'($signed(s_tdata[CW*i +: CW]));
                side0_reg.neg[i] <= d[AW-1];
                side0_reg.ad[i]  <= d[AW-1] ? AW'(-d) : AW'(d);
            end
            side0_reg.repel <= s_tuser[0];
            side0_reg.sf    <= s_tdata[6*CW];
            side0_reg.df    <= s_tdata[6*CW+1];

            for (int i = 0; i < 3; i++)
            begin
                sq1_reg[i] <= (2*AW)'(side0_reg.ad[i]) * (2*AW)'(side0_reg.ad[i]);
            end
            side1_reg <= side0_reg;

            sum2_reg <= pwsf_pkg::SUM_W'(sq1_reg[0]) + pwsf_pkg::SUM_W'(sq1_reg[1])
                      + pwsf_pkg::SUM_W'(sq1_reg[2]);
            side2_reg <= side1_reg;
        end
    end

    pwsf_isqrt u_isqrt (
        .clk      (clk),
        .en       (en),
        .rad      (sum2_reg),
        .side_in  (side2_reg),
        .root     (sep),
        .side_out (sq_side)
    );

    // Stretch and activity.
    always_comb
    begin
        stretch_next = {1'b0, sep} - SW'(eq_reg);
        cond_next    = sq_side.repel ? stretch_next[SW-1]
                                     : (!stretch_next[SW-1] && (stretch_next != '0));
        as_next      = stretch_next[SW-1] ? ASW'(-stretch_next) : ASW'(stretch_next);
        mid_next.ad    = sq_side.ad;
        mid_next.sep   = sep;
        mid_next.act   = cond_next && !(sq_side.sf && sq_side.df);
        mid_next.repel = sq_side.repel;
        mid_next.sf    = sq_side.sf;
        mid_next.df    = sq_side.df;
        for (int i = 0; i < 3; i++)
        begin
            mid_next.pos[i] = sq_side.repel ? sq_side.neg[i]
                                            : (!sq_side.neg[i] && (sq_side.ad[i] != '0));
        end
    end

    // Force magnitude, energy and force products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mid_reg[0] <= mid_next;
            as_reg[0]  <= as_next;

            p4_reg     <= pwsf_pkg::P_W'(k_reg) * pwsf_pkg::P_W'(as_reg[0]);
            mid_reg[1] <= mid_reg[0];
            as_reg[1]  <= as_reg[0];

            mm5_reg    <= MW'(p4_reg >> FB) + (mid_reg[1].repel ? MW'(rf_reg) : MW'(0));
            inner5_reg <= IW'(p4_reg)
                        + (mid_reg[1].repel ? (IW'(rf_reg) << (FB + 1)) : IW'(0));
            mid_reg[2] <= mid_reg[1];
            as_reg[2]  <= as_reg[1];

            for (int i = 0; i < 3; i++)
            begin
                fplo6_reg[i] <= (AW+MLW)'(mid_reg[2].ad[i]) * (AW+MLW)'(mm5_reg[MLW-1:0]);
                fphi6_reg[i] <= (AW+MHW)'(mid_reg[2].ad[i]) * (AW+MHW)'(mm5_reg[MW-1:MLW]);
            end
            eplo6_reg  <= (ASW+ILW)'(as_reg[2]) * (ASW+ILW)'(inner5_reg[ILW-1:0]);
            ephi6_reg  <= (ASW+IHW)'(as_reg[2]) * (ASW+IHW)'(inner5_reg[IW-1:ILW]);
            mid_reg[3] <= mid_reg[2];

            for (int i = 0; i < 3; i++)
            begin
                num7_reg[i] <= NW'(fplo6_reg[i]) + (NW'(fphi6_reg[i]) << MLW);
            end
            e7_reg     <= EW'(eplo6_reg) + (EW'(ephi6_reg) << ILW);
            mid_reg[4] <= mid_reg[3];
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        pwsf_div u_div (
            .clk (clk),
            .en  (en),
            .num (num7_reg[g]),
            .den (mid_reg[4].sep),
            .quo (quo[g])
        );
    end

    // Sideband that rides alongside the dividers.
    always_comb
    begin
        oside_next.energy = (e7_reg[EW-1:EH] != '0) ? '1 : e7_reg[EH-1:2*FB];
        oside_next.pos    = mid_reg[4].pos;
        oside_next.act    = mid_reg[4].act;
        oside_next.sf     = mid_reg[4].sf;
        oside_next.df     = mid_reg[4].df;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dside_reg[0] <= oside_next;
            for (int i = 1; i < DL; i++)
            begin
                dside_reg[i] <= dside_reg[i-1];
            end
        end
    end

    // Split between the ends, sign, saturation and the inactive case.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [QW-1:0] qh;
            qh = (!dside_reg[DL-1].sf && !dside_reg[DL-1].df) ? (quo[i] >> 1) : quo[i];
            src_acc_next[i] = (dside_reg[DL-1].act && !dside_reg[DL-1].sf)
                            ? sat_acc(qh, !dside_reg[DL-1].pos[i]) : '0;
            dst_acc_next[i] = (dside_reg[DL-1].act && !dside_reg[DL-1].df)
                            ? sat_acc(qh, dside_reg[DL-1].pos[i]) : '0;
        end
        energy_next = dside_reg[DL-1].act ? dside_reg[DL-1].energy : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata_reg <= {PAD'(0), dside_reg[DL-1].act, energy_next,
                            dst_acc_next[2], dst_acc_next[1], dst_acc_next[0],
                            src_acc_next[2], src_acc_next[1], src_acc_next[0]};
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule

// ===== rtl/pwsf_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
module pwsf_isqrt (
    input  logic                              clk,
    input  logic                              en,
    input  logic [pwsf_pkg::SUM_W-1:0]        rad,
    input  pwsf_pkg::sq_side_t                side_in,
    output logic [pwsf_pkg::DIST_W-1:0]       root,
    output pwsf_pkg::sq_side_t                side_out
);

    localparam int N  = pwsf_pkg::SQRT_LAT;
    localparam int RW = pwsf_pkg::SUM_W;
    localparam int DW = pwsf_pkg::DIST_W;
    localparam int TW = RW + 1;

    logic [RW-1:0]      rem_reg  [N];
    logic [DW-1:0]      root_reg [N];
    pwsf_pkg::sq_side_t side_reg [N];

    genvar j;
    for (j = 0; j < N; j++)
    begin : g_stage
        localparam int B = N - 1 - j;
        logic [RW-1:0]      rem_in;
        logic [DW-1:0]      root_in;
        pwsf_pkg::sq_side_t side_i;
        logic [TW-1:0]      trial;
        logic               take;

        if (j == 0)
        begin : g_first
            assign rem_in  = rad;
            assign root_in = '0;
            assign side_i  = side_in;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign side_i  = side_reg[j-1];
        end

        assign trial = (TW'(root_in) << (B + 1)) | (TW'(1) << (2 * B));
        assign take  = {1'b0, rem_in} >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= take ? RW'({1'b0, rem_in} - trial) : rem_in;
                root_reg[j] <= take ? (root_in | (DW'(1) << B)) : root_in;
                side_reg[j] <= side_i;
            end
        end
    end

    assign root     = root_reg[N-1];
    assign side_out = side_reg[N-1];

endmodule

// ===== rtl/pwsf_div.sv =====
// Pipelined restoring divider with an overflow clamp, one quotient bit per stage.
module pwsf_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [pwsf_pkg::N_W-1:0]      num,
    input  logic [pwsf_pkg::DIST_W-1:0]   den,
    output logic [pwsf_pkg::QC_W-1:0]     quo
);

    localparam int QB = pwsf_pkg::Q_BITS;
    localparam int RW = pwsf_pkg::R_W;
    localparam int DW = pwsf_pkg::DIST_W;
    localparam int NW = pwsf_pkg::N_W;
    localparam int QW = pwsf_pkg::QC_W;

    logic [RW-1:0] rem0_reg;
    logic [DW-1:0] den0_reg;
    logic          ovf0_reg;

    logic [RW-1:0] rem_reg [QB];
    logic [QB-1:0] q_reg   [QB];
    logic [DW-1:0] den_reg [QB];
    logic          ovf_reg [QB];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem0_reg <= num[RW-1:0];
            den0_reg <= den;
            ovf0_reg <= (num[NW-1:RW] != '0) || (num[RW-1:0] >= {den, QB'(0)});
        end
    end

    genvar j;
    for (j = 0; j < QB; j++)
    begin : g_stage
        localparam int B = QB - 1 - j;
        logic [RW-1:0] rem_in;
        logic [QB-1:0] q_in;
        logic [DW-1:0] den_in;
        logic          ovf_in;
        logic [RW-1:0] trial;
        logic          take;

        if (j == 0)
        begin : g_first
            assign rem_in = rem0_reg;
            assign q_in   = '0;
            assign den_in = den0_reg;
            assign ovf_in = ovf0_reg;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign den_in = den_reg[j-1];
            assign ovf_in = ovf_reg[j-1];
        end

        assign trial = RW'(den_in) << B;
        assign take  = rem_in >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= take ? (rem_in - trial) : rem_in;
                q_reg[j]   <= take ? (q_in | (QB'(1) << B)) : q_in;
                den_reg[j] <= den_in;
                ovf_reg[j] <= ovf_in;
            end
        end
    end

    assign quo = (den_reg[QB-1] == '0) ? '0 :
                 ovf_reg[QB-1] ? (QW'(1) << QB) : {1'b0, q_reg[QB-1]};

endmodule
